FILE: rtl/quoted_key_value_extractor_assert.svh
// Assertion helpers for the quoted key/value extractor.
`ifndef QUOTED_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define QUOTED_KEY_VALUE_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition in the same cycle as its trigger.
`define QKVE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qkve assertion failed");

// Check a condition in the cycle after its trigger.
`define QKVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qkve assertion failed");

`else

`define QKVE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QKVE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/qkve_pkg.sv
package qkve_pkg;

	localparam int BYTE_BITS        = 8;
	localparam int POS_BITS         = 4;
	localparam int KEY_LEN_BITS     = 4;
	localparam int CFG_DATA_BITS    = 64;
	localparam int MATCH_COUNT_BITS = 16;

	typedef logic [BYTE_BITS-1:0]    byte_t;
	typedef logic [POS_BITS-1:0]     pos_t;
	typedef logic [KEY_LEN_BITS-1:0] key_len_t;

	localparam byte_t QUOTE_CHAR     = 8'h22;
	localparam byte_t BACKSLASH_CHAR = 8'h5C;
	localparam pos_t  POS_MAX        = 4'd15;

	// Configuration register indexes
	typedef enum logic {
		REG_KEY_BYTES  = 1'b0,
		REG_KEY_LENGTH = 1'b1
	} cfg_index_t;

	// Per-byte decision from the scanner
	typedef struct packed {
		logic emit;
		logic last;
	} scan_res_t;

endpackage

FILE: rtl/qkve_if.sv
interface qkve_in_if;
	import qkve_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface qkve_out_if;
	import qkve_pkg::*;

	logic                        valid;
	logic                        ready;
	byte_t                       out_byte;
	logic                        value_last;
	logic [MATCH_COUNT_BITS-1:0] match_count;

	modport source (output valid, output out_byte, output value_last, output match_count,
		input ready);
	modport sink (input valid, input out_byte, input value_last, input match_count,
		output ready);
endinterface

FILE: rtl/quoted_key_value_extractor.sv
// Quoted key/value extractor: takes one text byte per item and, once a quoted
// string equal to the configured key has closed, passes the next quoted string
// (quotes included) to the output, marking its closing quote with value_last.
// A quote preceded by a backslash inside a string does not close it. The block
// takes one byte every cycle; a result appears in the cycle after its byte is
// taken, from a single output register. Input is held off only while that
// register is full and the output side is not taking it. Program key_bytes and
// key_length while the stream is idle; a key longer than KEY_MAX_BYTES never
// matches. match_count shows the low 16 bits of a saturating count of values.
`include "quoted_key_value_extractor_assert.svh"

module quoted_key_value_extractor #(
	parameter int KEY_MAX_BYTES = 8,
	parameter int COUNT_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  qkve_pkg::cfg_index_t                 cfg_index,
	input  logic [qkve_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	qkve_in_if.sink                              din,
	qkve_out_if.source                           dout
);
	import qkve_pkg::*;

	byte_t    key_q [KEY_MAX_BYTES];
	key_len_t key_length_q;

	logic      out_valid_q;
	byte_t     out_byte_q;
	logic      out_last_q;
	logic [MATCH_COUNT_BITS-1:0] out_count_q;

	logic                        accept;
	logic                        load;
	scan_res_t                   res;
	logic [COUNT_BITS-1:0]       count_q;
	logic [COUNT_BITS-1:0]       count_next;
	logic [MATCH_COUNT_BITS-1:0] count_low;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_MAX_BYTES; i++) begin
				key_q[i] <= '0;
			end
			key_length_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY_BYTES: begin
					for (int i = 0; i < KEY_MAX_BYTES; i++) begin
						key_q[i] <= cfg_data[BYTE_BITS*i +: BYTE_BITS];
					end
				end
				REG_KEY_LENGTH: begin
					key_length_q <= cfg_data[KEY_LEN_BITS-1:0];
				end
			endcase
		end
	end

	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;
	assign load      = accept && res.emit;

	qkve_scanner #(
		.KEY_MAX_BYTES(KEY_MAX_BYTES),
		.COUNT_BITS   (COUNT_BITS)
	) u_scanner (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.in_byte   (din.in_byte),
		.key       (key_q),
		.key_length(key_length_q),
		.res       (res),
		.count_q   (count_q),
		.count_next(count_next)
	);

	// Show the low bits of the count, zero-extended when narrower
	generate
		if (COUNT_BITS >= MATCH_COUNT_BITS) begin : g_count_trunc
			assign count_low = count_next[MATCH_COUNT_BITS-1:0];
		end else begin : g_count_ext
			assign count_low = {{(MATCH_COUNT_BITS-COUNT_BITS){1'b0}}, count_next};
		end
	endgenerate

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= din.in_byte;
			out_last_q  <= res.last;
			out_count_q <= count_low;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.out_byte    = out_byte_q;
	assign dout.value_last  = out_last_q;
	assign dout.match_count = out_count_q;

	`QKVE_ASSERT_NOW(a_last_is_quote, clk, arst_n, out_valid_q && out_last_q, out_byte_q == QUOTE_CHAR)
	`QKVE_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !din.ready, out_valid_q && !dout.ready)
	`QKVE_ASSERT_NEXT(a_count_never_drops, clk, arst_n, 1'b1, count_q >= $past(count_q))

endmodule

FILE: rtl/qkve_scanner.sv
module qkve_scanner #(
	parameter int KEY_MAX_BYTES = 8,
	parameter int COUNT_BITS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  qkve_pkg::byte_t     in_byte,
	input  qkve_pkg::byte_t     key [KEY_MAX_BYTES],
	input  qkve_pkg::key_len_t  key_length,
	output qkve_pkg::scan_res_t res,
	output logic [COUNT_BITS-1:0] count_q,
	output logic [COUNT_BITS-1:0] count_next
);
	import qkve_pkg::*;

	logic inside_q;
	logic last_bs_q;
	pos_t pos_q;
	logic mismatch_q;
	logic found_q;

	logic  inside_d;
	logic  last_bs_d;
	pos_t  pos_d;
	logic  mismatch_d;
	logic  found_d;
	byte_t key_byte;
	logic  is_quote;
	logic  key_hit;

	// Pick the key byte at the current compare position
	always_comb begin
		key_byte = '0;
		for (int i = 0; i < KEY_MAX_BYTES; i++) begin
			if (pos_q == POS_BITS'(i)) begin
				key_byte = key[i];
			end
		end
	end

	assign is_quote = (in_byte == QUOTE_CHAR);
	assign key_hit  = (pos_q < POS_BITS'(KEY_MAX_BYTES)) && (pos_q < key_length) &&
		(key_byte == in_byte);

	// Next state and per-byte decision
	always_comb begin
		inside_d   = inside_q;
		last_bs_d  = last_bs_q;
		pos_d      = pos_q;
		mismatch_d = mismatch_q;
		found_d    = found_q;
		count_next = count_q;
		res        = '0;
		if (!inside_q) begin
			// open a string on a quote, drop anything else
			if (is_quote) begin
				inside_d   = 1'b1;
				last_bs_d  = 1'b0;
				pos_d      = '0;
				mismatch_d = 1'b0;
				res.emit   = found_q;
			end
		end else if (is_quote && !last_bs_q) begin
			// close the string and decide whether it was the key
			inside_d  = 1'b0;
			last_bs_d = 1'b0;
			found_d   = !mismatch_q && (pos_q == key_length);
			if (found_q) begin
				if (count_q != '1) begin
					count_next = count_q + COUNT_BITS'(1);
				end
				res.emit = 1'b1;
				res.last = 1'b1;
			end
		end else begin
			// content byte: compare and advance
			if (!key_hit) begin
				mismatch_d = 1'b1;
			end
			if (pos_q != POS_MAX) begin
				pos_d = pos_q + POS_BITS'(1);
			end
			last_bs_d = (in_byte == BACKSLASH_CHAR);
			res.emit  = found_q;
		end
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			last_bs_q  <= 1'b0;
			pos_q      <= '0;
			mismatch_q <= 1'b0;
			found_q    <= 1'b0;
			count_q    <= '0;
		end else if (step) begin
			inside_q   <= inside_d;
			last_bs_q  <= last_bs_d;
			pos_q      <= pos_d;
			mismatch_q <= mismatch_d;
			found_q    <= found_d;
			count_q    <= count_next;
		end
	end

endmodule
